@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// Stand-alone header; it needs no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Checks that a condition in one cycle leads to another in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/mrrc_pkg.sv @@
// Types, codes and the CRC-16/MODBUS byte update for the read-response checker.
// Used by the top level and by its checker; depends on nothing else.
package mrrc_pkg;

   // Response status codes.
   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_FOREIGN     = 3'd1,
      STATUS_BAD_FUNC    = 3'd2,
      STATUS_CRC_ERROR   = 3'd3,
      STATUS_TOO_SHORT   = 3'd4
   } status_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MODULE_BASE_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_MODULE_COUNT        = 2'd1;
   localparam logic [1:0] CSR_REGISTER_BASE       = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [7:0] RESET_MODULE_BASE = 8'hC1;
   localparam logic [4:0] RESET_MODULE_COUNT = 5'd5;
   localparam logic [7:0] RESET_REGISTER_BASE = 8'h00;

   localparam logic [7:0]  FUNC_READ_INPUTS = 8'h02;
   localparam logic [4:0]  MAX_MODULES      = 5'd16;
   localparam logic [8:0]  POS_MAX          = 9'd511;
   localparam logic [15:0] CRC_INIT         = 16'hFFFF;
   localparam logic [15:0] CRC_POLY         = 16'hA001;
   localparam int          PAYLOAD_FIRST    = 3;
   localparam int          PAYLOAD_BYTES    = 6;

   // Response data layout.
   localparam int RSP_DATA_WIDTH = 64;
   localparam int RSP_USER_WIDTH = 3;

   // One byte of the reflected CRC-16/MODBUS update.
   function automatic logic [15:0] crc16_feed(input logic [15:0] crc,
                                              input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ design/modbus_read_response_checker_unit.sv @@
// Top level of the Modbus RTU read-response checker (function 0x02, CRC-16).
// Depends on mrrc_pkg.
//
//   channel   direction  handshake                   contents
//   req_      in         tvalid/tready, tlast        one frame byte, tlast on last byte
//   rsp_      out        tvalid/tready               status in tuser, words in tdata
//   csr_      in         write enable only           module window and register base
//
// One byte is taken in every cycle; the frame state and the byte-wide CRC update
// sit in one register stage, so the result of a frame is shown in the cycle after
// its last byte is taken. Reset is synchronous and restores the configuration
// defaults and an empty frame. While a result waits in the output register and
// the consumer is not ready, no request is accepted.
module modbus_read_response_checker_unit
   import mrrc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // req_tdata fields from bit 0: rx_byte[7:0]
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // rsp_tdata fields from bit 0: channel[3:0], reg_index[11:4],
   // word_first[27:12], word_second[43:28], word_third[59:44], zero[63:60]
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   // rsp_tuser fields from bit 0: status[2:0]
   output logic [RSP_USER_WIDTH-1:0] rsp_tuser,
   input  logic                      csr_wr_en,
   input  logic [1:0]                csr_index,
   input  logic [7:0]                csr_wdata
);

   logic [7:0]  cfg_base_addr_ff;
   logic [4:0]  cfg_module_count_ff;
   logic [7:0]  cfg_reg_base_ff;

   logic [8:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  func_ff, func_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  payload_ff [PAYLOAD_BYTES];
   logic [7:0]  payload_in [PAYLOAD_BYTES];
   logic [1:0]  match_ff, match_in;

   logic                      rsp_valid_ff;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   status_type                rsp_status_ff, rsp_status_in;

   logic        accept;
   logic        frame_done;
   logic [7:0]  addr_cur, func_cur, count_cur;
   logic [7:0]  payload_cur [PAYLOAD_BYTES];
   logic [1:0]  match_cur;
   logic [15:0] crc_cur;
   logic [8:0]  crc_last_pos;
   logic [4:0]  window;
   logic [7:0]  diff;
   logic [3:0]  chan;
   logic [7:0]  reg_index;
   logic [47:0] words;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign frame_done = accept && req_tlast;

   // Frame fields as they stand once the current byte is stored.
   always_comb begin
      addr_cur  = (pos_ff == 9'd0) ? req_tdata : addr_ff;
      func_cur  = (pos_ff == 9'd1) ? req_tdata : func_ff;
      count_cur = (pos_ff == 9'd2) ? req_tdata : byte_count_ff;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         payload_cur[i] = (pos_ff == 9'(PAYLOAD_FIRST + i)) ? req_tdata : payload_ff[i];
      end
      crc_last_pos = {1'b0, count_cur} + 9'd2;
      match_cur    = match_ff;
      crc_cur      = crc_ff;
      if (pos_ff <= crc_last_pos) begin
         crc_cur = crc16_feed(crc_ff, req_tdata);
      end else if (pos_ff == crc_last_pos + 9'd1) begin
         if (req_tdata == crc_ff[7:0]) begin
            match_cur[0] = 1'b1;
         end
      end else if (pos_ff == crc_last_pos + 9'd2) begin
         if (req_tdata == crc_ff[15:8]) begin
            match_cur[1] = 1'b1;
         end
      end
   end

   // Result of the frame that ends with the current byte.
   always_comb begin
      window    = (cfg_module_count_ff > MAX_MODULES) ? MAX_MODULES : cfg_module_count_ff;
      diff      = addr_cur - cfg_base_addr_ff;
      chan      = 4'd0;
      reg_index = 8'd0;
      if ({1'b0, diff} >= {4'd0, window}) begin
         rsp_status_in = STATUS_FOREIGN;
      end else begin
         chan      = diff[3:0];
         reg_index = cfg_reg_base_ff + {4'd0, chan} + {3'd0, chan, 1'b0};
         if (func_cur != FUNC_READ_INPUTS) begin
            rsp_status_in = STATUS_BAD_FUNC;
         end else if (pos_ff < crc_last_pos + 9'd2) begin
            rsp_status_in = STATUS_TOO_SHORT;
         end else if (match_cur != 2'b11) begin
            rsp_status_in = STATUS_CRC_ERROR;
         end else begin
            rsp_status_in = STATUS_OK;
         end
      end
      words = 48'd0;
      if (rsp_status_in == STATUS_OK) begin
         words = {payload_cur[4], payload_cur[5], payload_cur[2], payload_cur[3],
                  payload_cur[0], payload_cur[1]};
      end
      rsp_data_in = {4'd0, words, reg_index, chan};
   end

   // Next frame state; the last byte of a frame starts a fresh one.
   always_comb begin
      if (frame_done) begin
         pos_in        = 9'd0;
         crc_in        = CRC_INIT;
         addr_in       = 8'd0;
         func_in       = 8'd0;
         byte_count_in = 8'd0;
         match_in      = 2'b00;
         for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            payload_in[i] = 8'd0;
         end
      end else begin
         pos_in        = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 9'd1;
         crc_in        = crc_cur;
         addr_in       = addr_cur;
         func_in       = func_cur;
         byte_count_in = count_cur;
         match_in      = match_cur;
         for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            payload_in[i] = payload_cur[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= 9'd0;
         crc_ff        <= CRC_INIT;
         addr_ff       <= 8'd0;
         func_ff       <= 8'd0;
         byte_count_ff <= 8'd0;
         match_ff      <= 2'b00;
         for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            payload_ff[i] <= 8'd0;
         end
      end else if (accept) begin
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         addr_ff       <= addr_in;
         func_ff       <= func_in;
         byte_count_ff <= byte_count_in;
         match_ff      <= match_in;
         for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            payload_ff[i] <= payload_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_base_addr_ff    <= RESET_MODULE_BASE;
         cfg_module_count_ff <= RESET_MODULE_COUNT;
         cfg_reg_base_ff     <= RESET_REGISTER_BASE;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MODULE_BASE_ADDRESS: cfg_base_addr_ff    <= csr_wdata;
            CSR_MODULE_COUNT:        cfg_module_count_ff <= csr_wdata[4:0];
            CSR_REGISTER_BASE:       cfg_reg_base_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (frame_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

@@ design/mrrc_checker.sv @@
// Port-level assertions for the read-response checker, bound to its top level.
// Depends on mrrc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mrrc_checker
   import mrrc_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      req_tlast,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic [RSP_USER_WIDTH-1:0] rsp_tuser
);

   // A stalled response holds its contents.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

   // The last byte of a frame always yields a response in the next cycle.
   `ASSERT_NEXT(a_frame_rsp, clock, reset, req_tvalid && req_tready && req_tlast, rsp_tvalid, "no response after last byte")

   // Data words are only reported for a good frame.
   `ASSERT_CLK(a_words_zero, clock, reset, !(rsp_tvalid && rsp_tuser != STATUS_OK) || rsp_tdata[63:12] == 52'd0, "words set on a failed frame")

   // A foreign address carries neither a channel nor a register index.
   `ASSERT_CLK(a_foreign_chan, clock, reset, !(rsp_tvalid && rsp_tuser == STATUS_FOREIGN) || rsp_tdata[11:0] == 12'd0, "channel set for foreign address")

endmodule

bind modbus_read_response_checker_unit mrrc_checker u_mrrc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
